@@ sv/twl_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twl_pkg
// Shared types and constants of the two-wire handshake byte link.
// ---------------------------------------------------------------------------
package twl_pkg;

	// opcodes carried by each input word
	localparam logic [1:0] OP_IDLE = 2'd0;
	localparam logic [1:0] OP_TX   = 2'd1;
	localparam logic [1:0] OP_RX   = 2'd2;

	// configuration register indexes
	localparam logic [0:0] CFG_IDX_TIMEOUT = 1'b0;
	localparam logic [0:0] CFG_IDX_REPLY   = 1'b1;

	// configuration widths and reset values
	localparam int TIMEOUT_W = 24;
	localparam int REPLY_W   = 16;
	localparam int CFG_W     = 24;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd2000000;
	localparam logic [REPLY_W-1:0]   REPLY_RST   = 16'd100;

	// line drive codes, bit 0 pulls tip, bit 1 pulls ring
	localparam logic [1:0] DRV_NONE = 2'b00;
	localparam logic [1:0] DRV_TIP  = 2'b01;
	localparam logic [1:0] DRV_RING = 2'b10;

	// index of the last bit of a byte
	localparam logic [2:0] BIT_LAST = 3'd7;

	// stream widths
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TX_LOW,
		PH_TX_HIGH,
		PH_RX_WAIT,
		PH_RX_DELAY,
		PH_RX_ACK
	} phase_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [REPLY_W-1:0]   reply_delay_ticks;
	} twl_cfg_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] tx_byte;
		logic       tip_level;
		logic       ring_level;
	} twl_item_t;

	typedef struct packed {
		logic       tip_pull_low;
		logic       ring_pull_low;
		logic       busy_res;
		logic       done_res;
		logic       timed_out;
		logic [7:0] rx_data;
	} twl_res_t;

endpackage

@@ sv/twl_cfg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twl_cfg
// Configuration registers: handshake timeout and reply delay.
// ---------------------------------------------------------------------------
module twl_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [twl_pkg::CFG_W-1:0] cfg_data,
	output twl_pkg::twl_cfg_t        cfg
);
	import twl_pkg::*;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic [REPLY_W-1:0]   reply_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			reply_q   <= REPLY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_TIMEOUT: timeout_q <= cfg_data[TIMEOUT_W-1:0];
				CFG_IDX_REPLY:   reply_q   <= cfg_data[REPLY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.timeout_ticks     = timeout_q;
	assign cfg.reply_delay_ticks = reply_q;

endmodule

@@ sv/twl_step.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// twl_step
// Handshake state machine: takes one sampled word per enabled cycle,
// updates the link state and produces that word's result.
// ---------------------------------------------------------------------------
module twl_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  twl_pkg::twl_item_t item,
	input  twl_pkg::twl_cfg_t  cfg,
	output twl_pkg::twl_res_t  res
);
	import twl_pkg::*;

	phase_t               phase_q, phase_d;
	logic [2:0]           bit_q, bit_d;
	logic [7:0]           shift_q, shift_d;
	logic [TIMEOUT_W-1:0] wait_q, wait_d;
	logic [REPLY_W-1:0]   delay_q, delay_d;
	logic [1:0]           drive_q, drive_d;

	logic [TIMEOUT_W-1:0] wait_inc;
	logic                 wait_hit;
	logic [REPLY_W-1:0]   delay_dec;
	logic                 tx_ok_low;
	logic                 tx_ok_high;
	logic                 ack_ok;
	logic                 done;
	logic                 tout;
	logic [7:0]           rxd;

	// wait counter and delay counter helpers
	assign wait_inc   = wait_q + TIMEOUT_W'(1);
	assign wait_hit   = (wait_inc >= cfg.timeout_ticks) || (wait_inc == '0);
	assign delay_dec  = delay_q - REPLY_W'(1);
	assign tx_ok_low  = shift_q[0] ? !item.tip_level : !item.ring_level;
	assign tx_ok_high = shift_q[0] ? item.tip_level : item.ring_level;
	assign ack_ok     = shift_q[7] ? item.ring_level : item.tip_level;

	// next state
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		wait_d  = wait_q;
		delay_d = delay_q;
		drive_d = drive_q;
		done    = 1'b0;
		tout    = 1'b0;
		rxd     = 8'd0;
		case (phase_q)
			PH_IDLE: begin
				if (item.opcode == OP_TX) begin
					shift_d = item.tx_byte;
					bit_d   = 3'd0;
					drive_d = item.tx_byte[0] ? DRV_RING : DRV_TIP;
					wait_d  = '0;
					phase_d = PH_TX_LOW;
				end else if (item.opcode == OP_RX) begin
					shift_d = 8'd0;
					bit_d   = 3'd0;
					drive_d = DRV_NONE;
					phase_d = PH_RX_WAIT;
				end
			end
			PH_TX_LOW: begin
				if (tx_ok_low) begin
					drive_d = DRV_NONE;
					wait_d  = '0;
					phase_d = PH_TX_HIGH;
				end else begin
					wait_d = wait_inc;
					if (wait_hit) begin
						done = 1'b1;
						tout = 1'b1;
					end
				end
			end
			PH_TX_HIGH: begin
				if (tx_ok_high) begin
					if (bit_q == BIT_LAST) begin
						done = 1'b1;
					end else begin
						bit_d   = bit_q + 3'd1;
						shift_d = {1'b0, shift_q[7:1]};
						drive_d = shift_q[1] ? DRV_RING : DRV_TIP;
						wait_d  = '0;
						phase_d = PH_TX_LOW;
					end
				end else begin
					wait_d = wait_inc;
					if (wait_hit) begin
						done = 1'b1;
						tout = 1'b1;
					end
				end
			end
			PH_RX_WAIT: begin
				// no timeout while both lines sit high
				if (!(item.tip_level && item.ring_level)) begin
					shift_d = {item.tip_level, shift_q[7:1]};
					if (cfg.reply_delay_ticks == '0) begin
						drive_d = item.tip_level ? DRV_TIP : DRV_RING;
						wait_d  = '0;
						phase_d = PH_RX_ACK;
					end else begin
						delay_d = cfg.reply_delay_ticks;
						phase_d = PH_RX_DELAY;
					end
				end
			end
			PH_RX_DELAY: begin
				delay_d = delay_dec;
				if (delay_dec == '0) begin
					drive_d = shift_q[7] ? DRV_TIP : DRV_RING;
					wait_d  = '0;
					phase_d = PH_RX_ACK;
				end
			end
			PH_RX_ACK: begin
				if (ack_ok) begin
					drive_d = DRV_NONE;
					if (bit_q == BIT_LAST) begin
						done = 1'b1;
						rxd  = shift_q;
					end else begin
						bit_d   = bit_q + 3'd1;
						phase_d = PH_RX_WAIT;
					end
				end else begin
					wait_d = wait_inc;
					if (wait_hit) begin
						done = 1'b1;
						tout = 1'b1;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				drive_d = DRV_NONE;
			end
		endcase
		// end of transfer releases both wires
		if (done) begin
			phase_d = PH_IDLE;
			drive_d = DRV_NONE;
			wait_d  = '0;
			delay_d = '0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			wait_q  <= '0;
			delay_q <= '0;
			drive_q <= DRV_NONE;
		end else if (step_en) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			wait_q  <= wait_d;
			delay_q <= delay_d;
			drive_q <= drive_d;
		end
	end

	// result of this word
	always_comb begin
		res.tip_pull_low  = drive_d[0];
		res.ring_pull_low = drive_d[1];
		res.busy_res      = (phase_d != PH_IDLE);
		res.done_res      = done;
		res.timed_out     = tout;
		res.rx_data       = rxd;
	end

`ifndef SYNTHESIS
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> drive_q == DRV_NONE)
		else $error("idle link still drives a wire");
	a_one_wire: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q != 2'b11)
		else $error("both wires pulled low");
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && done |=> phase_q == PH_IDLE && wait_q == '0)
		else $error("transfer end did not return to idle");
	a_rx_wait_free: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RX_WAIT || phase_q == PH_TX_HIGH |-> drive_q == DRV_NONE)
		else $error("wire driven while waiting for partner");
	a_rxd_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rxd != 8'd0 |-> done && !tout && phase_q == PH_RX_ACK)
		else $error("received byte outside successful receive end");
`endif

endmodule

@@ sv/two_wire_handshake_byte_link_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_wire_handshake_byte_link_core
// Tip/ring open-drain handshake byte transceiver, one sampled tick per word.
//
// channel   | direction | content
// s_axis    | in        | sampled line levels and opcode, one word per tick
// m_axis    | out       | wire drives, busy/done/timeout flags, received byte
// cfg       | in        | write-only timeout and reply delay registers
//
// One word is accepted every cycle while m_axis is not stalled; its result
// passes the input register, then the state machine step into the output
// register, and is then on m_axis.
// The rate is set by the state machine loop.
// Reset clears the link to idle with both wires released and loads the
// default timeout and reply delay.
// A stall on m_axis holds the output register and the state machine; it
// holds the input register and drops s_axis_tready only when that register is full.
// ---------------------------------------------------------------------------
module two_wire_handshake_byte_link_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// opcode[1:0], tx_byte[9:2], tip_level[10], ring_level[11], zero[15:12]
	input  logic [twl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tip_pull_low[0], ring_pull_low[1], busy_res[2], done_res[3],
	// timed_out[4], rx_data[12:5], zero[15:13]
	output logic [twl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_index,
	input  logic [twl_pkg::CFG_W-1:0]       cfg_data
);
	import twl_pkg::*;

	twl_cfg_t  cfg;
	twl_item_t item_s1;
	logic      vld_s1;
	twl_res_t  res;
	twl_res_t  res_q;
	logic      out_vld_q;
	logic      out_free;
	logic      step_en;

	twl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake control
	assign out_free      = !out_vld_q || m_axis_tready;
	assign step_en       = vld_s1 && out_free;
	assign s_axis_tready = !vld_s1 || step_en;

	// input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.opcode     <= s_axis_tdata[1:0];
			item_s1.tx_byte    <= s_axis_tdata[9:2];
			item_s1.tip_level  <= s_axis_tdata[10];
			item_s1.ring_level <= s_axis_tdata[11];
		end
	end

	twl_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= step_en;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {3'b000, res_q.rx_data, res_q.timed_out, res_q.done_res,
		res_q.busy_res, res_q.ring_pull_low, res_q.tip_pull_low};

endmodule

@@ bench/tb_two_wire_handshake_byte_link_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_two_wire_handshake_byte_link_core
// Self-checking bench for the tip/ring handshake byte link. A partner model
// answers the line drives predicted for the block, so most words form real
// transmit and receive handshakes; slow answers, line noise and stray
// opcodes break some of them. Every result word is checked field by field
// against an in-bench model of the link state machine.
// ---------------------------------------------------------------------------
module tb_two_wire_handshake_byte_link_core;
	import twl_pkg::*;

	// opcode that the link treats as an idle tick
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CFG_IDX_TIMEOUT;
	logic [CFG_W-1:0] cfg_data = '0;

	// link model state and registers
	phase_t link_phase = PH_IDLE;
	logic [2:0] link_bit = '0;
	logic [7:0] link_shift = '0;
	logic [TIMEOUT_W-1:0] link_wait = '0;
	logic [REPLY_W-1:0] link_delay = '0;
	logic [1:0] link_drive = DRV_NONE;
	logic [TIMEOUT_W-1:0] cfg_timeout = TIMEOUT_RST;
	logic [REPLY_W-1:0] cfg_reply = REPLY_RST;

	// partner on the far end of the wires
	logic [1:0] p_pull = DRV_NONE;
	logic [7:0] p_byte = '0;
	logic [2:0] p_idx = '0;
	int p_hold = 0;
	int p_slow = 0;
	int p_noise = 0;

	twl_res_t expected_q[$];
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int sink_wait = 0;
	int errors = 0;
	int n_words = 0;
	int n_results = 0;
	int n_tx = 0;
	int n_rx = 0;
	int n_done = 0;
	int n_tout = 0;

	two_wire_handshake_byte_link_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// one failing wait tick, true once the wait has run out
	function automatic logic wait_expired();
		link_wait = link_wait + 1'b1;
		return (link_wait >= cfg_timeout) || (link_wait == '0);
	endfunction

	function automatic void drive_tx_bit();
		link_drive = link_shift[0] ? DRV_RING : DRV_TIP;
		link_wait = '0;
		link_phase = PH_TX_LOW;
	endfunction

	function automatic void start_ack();
		link_drive = link_shift[7] ? DRV_TIP : DRV_RING;
		link_wait = '0;
		link_phase = PH_RX_ACK;
	endfunction

	// advance the link model by one tick and return the expected result
	function automatic twl_res_t step_link(input logic [1:0] op, input logic [7:0] txb,
	                                       input logic tip, input logic ring);
		twl_res_t r;
		logic done;
		logic tout;
		logic ok;
		logic [7:0] rxd;
		done = 1'b0;
		tout = 1'b0;
		rxd = '0;
		case (link_phase)
			PH_IDLE: begin
				if (op == OP_TX) begin
					link_shift = txb;
					link_bit = '0;
					drive_tx_bit();
				end else if (op == OP_RX) begin
					link_shift = '0;
					link_bit = '0;
					link_drive = DRV_NONE;
					link_phase = PH_RX_WAIT;
				end
			end
			PH_TX_LOW: begin
				ok = link_shift[0] ? !tip : !ring;
				if (ok) begin
					link_drive = DRV_NONE;
					link_wait = '0;
					link_phase = PH_TX_HIGH;
				end else if (wait_expired()) begin
					done = 1'b1;
					tout = 1'b1;
				end
			end
			PH_TX_HIGH: begin
				ok = link_shift[0] ? tip : ring;
				if (ok) begin
					if (link_bit >= BIT_LAST) begin
						done = 1'b1;
					end else begin
						link_bit = link_bit + 1'b1;
						link_shift = link_shift >> 1;
						drive_tx_bit();
					end
				end else if (wait_expired()) begin
					done = 1'b1;
					tout = 1'b1;
				end
			end
			PH_RX_WAIT: begin
				if (!(tip && ring)) begin
					link_shift = {tip, link_shift[7:1]};
					if (cfg_reply == '0) begin
						start_ack();
					end else begin
						link_delay = cfg_reply;
						link_phase = PH_RX_DELAY;
					end
				end
			end
			PH_RX_DELAY: begin
				link_delay = link_delay - 1'b1;
				if (link_delay == '0)
					start_ack();
			end
			PH_RX_ACK: begin
				ok = link_shift[7] ? ring : tip;
				if (ok) begin
					link_drive = DRV_NONE;
					if (link_bit >= BIT_LAST) begin
						done = 1'b1;
						rxd = link_shift;
					end else begin
						link_bit = link_bit + 1'b1;
						link_phase = PH_RX_WAIT;
					end
				end else if (wait_expired()) begin
					done = 1'b1;
					tout = 1'b1;
				end
			end
			default: begin
				link_phase = PH_IDLE;
				link_drive = DRV_NONE;
			end
		endcase
		// end or abort releases both wires
		if (done) begin
			link_phase = PH_IDLE;
			link_drive = DRV_NONE;
			link_wait = '0;
			link_delay = '0;
		end
		r.tip_pull_low = link_drive[0];
		r.ring_pull_low = link_drive[1];
		r.busy_res = (link_phase != PH_IDLE);
		r.done_res = done;
		r.timed_out = tout;
		r.rx_data = rxd;
		return r;
	endfunction

	// partner answers the predicted drives after a random delay
	task automatic partner_levels(output logic tip, output logic ring);
		logic [1:0] want;
		want = p_pull;
		case (link_phase)
			PH_TX_LOW: want = (link_drive == DRV_RING) ? DRV_TIP : DRV_RING;
			PH_TX_HIGH, PH_RX_ACK, PH_IDLE: want = DRV_NONE;
			PH_RX_WAIT: begin
				if (p_pull == DRV_NONE)
					want = p_byte[p_idx] ? DRV_RING : DRV_TIP;
			end
			default: ;
		endcase
		if (want != p_pull) begin
			if (p_hold == 0) begin
				if (link_phase == PH_RX_WAIT)
					p_idx = p_idx + 1'b1;
				p_pull = want;
				p_hold = $urandom_range(0, p_slow);
			end else begin
				p_hold = p_hold - 1;
			end
		end
		// wired-and of both ends
		tip = !(link_drive[0] | p_pull[0]);
		ring = !(link_drive[1] | p_pull[1]);
		if (p_noise != 0 && $urandom_range(1, 100) <= p_noise)
			{tip, ring} = 2'($urandom_range(0, 3));
	endtask

	// offer one word, predict its result once accepted
	task automatic send_tick(input logic [1:0] op, input logic [7:0] txb);
		logic tip;
		logic ring;
		partner_levels(tip, ring);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, ring, tip, txb, op};
		do @(posedge clk); while (!s_axis_tready);
		expected_q.push_back(step_link(op, txb, tip, ring));
		n_words++;
	endtask

	// tick until the link is idle, with stray opcodes now and then
	task automatic settle_link();
		logic [1:0] op;
		while (link_phase != PH_IDLE) begin
			op = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : OP_IDLE;
			send_tick(op, 8'($urandom));
		end
	endtask

	task automatic do_transfer(input logic [1:0] op, input logic [7:0] txb,
	                           input logic [7:0] rxb);
		p_byte = rxb;
		p_idx = '0;
		if (op == OP_TX)
			n_tx++;
		else if (op == OP_RX)
			n_rx++;
		send_tick(op, txb);
		settle_link();
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDX_TIMEOUT)
			cfg_timeout = val[TIMEOUT_W-1:0];
		else
			cfg_reply = val[REPLY_W-1:0];
	endtask

	// idle ticks with noisy levels and the unused opcode
	task automatic test_idle_ticks();
		p_noise = 50;
		repeat (4) send_tick(OP_IDLE, 8'($urandom));
		repeat (4) send_tick(OP_UNUSED, 8'($urandom));
		p_noise = 0;
	endtask

	task automatic test_transmit_extremes();
		do_transfer(OP_TX, 8'h00, 8'h00);
		do_transfer(OP_TX, 8'hFF, 8'h00);
		do_transfer(OP_TX, 8'hA5, 8'h00);
	endtask

	// short reply delay keeps the receive handshakes brief
	task automatic test_receive_extremes();
		write_reg(CFG_IDX_REPLY, 24'd4);
		do_transfer(OP_RX, 8'h00, 8'h00);
		do_transfer(OP_RX, 8'hFF, 8'hFF);
	endtask

	// start opcodes while a transfer runs must be ignored
	task automatic test_busy_opcodes();
		n_tx++;
		send_tick(OP_TX, 8'h3C);
		send_tick(OP_RX, 8'hFF);
		send_tick(OP_TX, 8'h00);
		send_tick(OP_UNUSED, 8'h81);
		settle_link();
		p_byte = 8'h96;
		p_idx = '0;
		n_rx++;
		send_tick(OP_RX, 8'h00);
		send_tick(OP_TX, 8'hFF);
		send_tick(OP_RX, 8'h55);
		settle_link();
	endtask

	task automatic test_zero_reply_delay();
		write_reg(CFG_IDX_REPLY, '0);
		p_slow = 1;
		do_transfer(OP_RX, 8'h00, 8'hA5);
		do_transfer(OP_RX, 8'hFF, 8'h3C);
	endtask

	// zero timeout aborts on the first missed tick
	task automatic test_zero_timeout();
		write_reg(CFG_IDX_TIMEOUT, '0);
		p_slow = 4;
		repeat (3) do_transfer(OP_TX, 8'($urandom), 8'($urandom));
		repeat (3) do_transfer(OP_RX, 8'($urandom), 8'($urandom));
		p_slow = 0;
	endtask

	task automatic test_random_traffic();
		int stop_at;
		logic [CFG_W-1:0] tmo;
		stop_at = n_words + 500;
		while (n_words < stop_at) begin
			case ($urandom_range(0, 3))
				0: tmo = CFG_W'($urandom_range(1, 6));
				1: tmo = CFG_W'($urandom_range(7, 300));
				2: tmo = {CFG_W{1'b1}};
				default: tmo = '0;
			endcase
			write_reg(CFG_IDX_TIMEOUT, tmo);
			write_reg(CFG_IDX_REPLY,
			          CFG_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6)));
			p_slow = $urandom_range(0, 8);
			p_noise = ($urandom_range(0, 2) == 0) ? 4 : 0;
			repeat (2) begin
				repeat ($urandom_range(0, 3))
					send_tick(($urandom_range(0, 1) == 0) ? OP_IDLE : OP_UNUSED, 8'($urandom));
				do_transfer(2'($urandom_range(1, 2)), 8'($urandom), 8'($urandom));
			end
			p_noise = 0;
			settle_link();
		end
	endtask

	// long result stall while words keep coming
	task automatic test_backpressure();
		write_reg(CFG_IDX_TIMEOUT, 24'd50);
		write_reg(CFG_IDX_REPLY, 24'd2);
		p_slow = 2;
		hold_req = 1'b1;
		repeat (10) do_transfer(2'($urandom_range(1, 2)), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_extreme_settings();
		write_reg(CFG_IDX_TIMEOUT, {CFG_W{1'b1}});
		write_reg(CFG_IDX_REPLY, 24'd20);
		p_slow = 3;
		do_transfer(OP_RX, 8'h00, 8'h5A);
		do_transfer(OP_TX, 8'hC3, 8'h00);
		write_reg(CFG_IDX_TIMEOUT, 24'd1);
		write_reg(CFG_IDX_REPLY, 24'd1);
		p_slow = 0;
		do_transfer(OP_TX, 8'h6E, 8'h00);
		do_transfer(OP_RX, 8'h00, 8'hE7);
	endtask

	// result side ready, with stall bursts and one long hold on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			sink_wait = LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (sink_wait > 0) begin
			sink_wait = sink_wait - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			sink_wait = $urandom_range(0, 11);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
		if (exp !== act) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
		end
	endtask

	// compare each result word with the oldest prediction
	always @(posedge clk) begin : check_results
		twl_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word %0h, nothing expected", $time,
				         m_axis_tdata);
			end else begin
				want = expected_q.pop_front();
				n_results++;
				if (want.done_res)
					n_done++;
				if (want.timed_out)
					n_tout++;
				check_field("tip_pull_low", 8'(want.tip_pull_low), 8'(m_axis_tdata[0]));
				check_field("ring_pull_low", 8'(want.ring_pull_low), 8'(m_axis_tdata[1]));
				check_field("busy_res", 8'(want.busy_res), 8'(m_axis_tdata[2]));
				check_field("done_res", 8'(want.done_res), 8'(m_axis_tdata[3]));
				check_field("timed_out", 8'(want.timed_out), 8'(m_axis_tdata[4]));
				check_field("rx_data", want.rx_data, m_axis_tdata[12:5]);
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_transmit_extremes();
		test_receive_extremes();
		test_busy_opcodes();
		test_zero_reply_delay();
		test_zero_timeout();
		test_random_traffic();
		test_backpressure();
		// last part runs without idling on either side
		idle_on = 1'b0;
		test_extreme_settings();
		drain_results();
		repeat (10) @(posedge clk);
		$display("run: %0d words, %0d results, %0d transmits and %0d receives started",
		         n_words, n_results, n_tx, n_rx);
		$display("run: %0d transfers ended, %0d of them on timeout", n_done, n_tout);
		if (errors == 0)
			$display("tb_two_wire_handshake_byte_link_core OK");
		else
			$display("tb_two_wire_handshake_byte_link_core NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#6000000;
		$display("tb_two_wire_handshake_byte_link_core NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
sv/twl_pkg.sv
sv/twl_cfg.sv
sv/twl_step.sv
sv/two_wire_handshake_byte_link_core.sv
bench/tb_two_wire_handshake_byte_link_core.sv
